>>> rtl/nba_pkg.sv
// Shared types and constants for the neighbor bearing angle pipeline.
`timescale 1ns / 1ps

package nba_pkg;

  // Coordinate difference width after the longitude wrap.
  localparam int XW = 27;
  // CORDIC x/y datapath width after normalization (magnitude below 2^40, gain ~1.65).
  localparam int DW = 44;
  // Angle accumulator width, Q30 radians.
  localparam int ZW = 34;
  // Normalizing shift amount width.
  localparam int KW = 6;
  // Normalize until the larger magnitude has its leading one at this bit.
  localparam int NORM_EXP = 39;

  localparam int TABLE_LEN = 24;
  localparam int ANGLE_W = 19;
  localparam int ROUND_SHIFT = 14;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] ROUND_BIAS = 34'sd8192;
  localparam logic signed [ZW-1:0] ANGLE_LIMIT = 34'sd205887;

  // atan(2^-i) in Q30, truncated.
  localparam logic signed [ZW-1:0] ATAN_Q30 [TABLE_LEN] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
    34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
    34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
    34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
    34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1023,      34'sd511,       34'sd255,       34'sd127
  };

  // Starting value of the angle accumulator after the quarter turn.
  typedef enum logic [1:0] {
    ZS_NONE,
    ZS_POS,
    ZS_NEG
  } nba_zstart_t;

  // Status that rides along with each transaction.
  typedef struct packed {
    logic ok;   // center not at a pole and neighbor present
    logic nz;   // the two points differ
  } nba_tag_t;

endpackage

>>> rtl/nba_front.sv
// Front stages: coordinate differences, longitude wrap, quarter turn.
`timescale 1ns / 1ps

module nba_front import nba_pkg::*; #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [23:0]      clat,
  input  logic signed [24:0]      clon,
  input  logic signed [23:0]      nlat,
  input  logic signed [24:0]      nlon,
  input  logic                    present,
  output logic                    out_vld,
  output nba_tag_t                out_tag,
  output logic signed [XW-1:0]    out_x,
  output logic signed [XW-1:0]    out_y,
  output nba_zstart_t             out_zs,
  output logic        [XW-1:0]    out_orm
);

  // Wide enough for 360 degrees at any fraction width.
  localparam int WW = (COORD_FRAC_BITS + 10 > XW) ? COORD_FRAC_BITS + 10 : XW;
  localparam logic signed [WW-1:0] DEG90  = WW'(64'(90) << COORD_FRAC_BITS);
  localparam logic signed [WW-1:0] DEG180 = WW'(64'(180) << COORD_FRAC_BITS);
  localparam logic signed [WW-1:0] DEG360 = WW'(64'(360) << COORD_FRAC_BITS);

  logic signed [WW-1:0] lon_d, lon_w, alat, clat_w;
  logic signed [XW-1:0] dx_next, dy_next;
  logic                 ok_next;

  // Stage 1 registers
  logic                 vld1;
  logic                 ok1;
  logic signed [XW-1:0] dx, dy;

  // Stage 2 next values
  logic signed [XW-1:0] x_next, y_next;
  logic        [XW-1:0] ay;
  nba_zstart_t          zs_next;

  always_comb begin
    lon_d  = WW'(nlon) - WW'(clon);
    if (lon_d > DEG180) begin
      lon_w = lon_d - DEG360;
    end else if (lon_d < -DEG180) begin
      lon_w = lon_d + DEG360;
    end else begin
      lon_w = lon_d;
    end
    dx_next = XW'(lon_w);
    dy_next = XW'(nlat) - XW'(clat);
    clat_w  = WW'(clat);
    alat    = clat_w[WW-1] ? -clat_w : clat_w;
    ok_next = (alat < DEG90) && present;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1 <= ok_next;
      dx  <= dx_next;
      dy  <= dy_next;
    end
  end

  // Turn a vector in the left half plane by a quarter turn toward the x axis.
  always_comb begin
    if (dx[XW-1]) begin
      if (!dy[XW-1]) begin
        x_next  = dy;
        y_next  = -dx;
        zs_next = ZS_POS;
      end else begin
        x_next  = -dy;
        y_next  = dx;
        zs_next = ZS_NEG;
      end
    end else begin
      x_next  = dx;
      y_next  = dy;
      zs_next = ZS_NONE;
    end
    ay = y_next[XW-1] ? XW'(-y_next) : XW'(y_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag.ok <= ok1;
      out_tag.nz <= (dx != '0) || (dy != '0);
      out_x      <= x_next;
      out_y      <= y_next;
      out_zs     <= zs_next;
      // x is never negative here; the OR keeps the leading one of the larger magnitude
      out_orm    <= XW'(x_next) | ay;
    end
  end

endmodule

>>> rtl/nba_norm.sv
// Two-stage normalizer: leading-one search, then left shift to the CORDIC width.
`timescale 1ns / 1ps

module nba_norm import nba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  nba_tag_t             in_tag,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  nba_zstart_t          in_zs,
  input  logic        [XW-1:0] in_orm,
  output logic                 out_vld,
  output nba_tag_t             out_tag,
  output logic signed [DW-1:0] out_x,
  output logic signed [DW-1:0] out_y,
  output logic signed [ZW-1:0] out_z
);

  logic        [KW-1:0] lead;
  logic        [KW-1:0] k_next;

  logic                 vld3;
  nba_tag_t             tag3;
  logic signed [XW-1:0] x3, y3;
  nba_zstart_t          zs3;
  logic        [KW-1:0] k;

  logic signed [ZW-1:0] z_next;

  always_comb begin
    lead = '0;
    for (int i = 0; i < XW; i++) begin
      if (in_orm[i]) begin
        lead = KW'(i);
      end
    end
    k_next = KW'(NORM_EXP) - lead;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (en) begin
      vld3 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag3 <= in_tag;
      x3   <= in_x;
      y3   <= in_y;
      zs3  <= in_zs;
      k    <= k_next;
    end
  end

  always_comb begin
    case (zs3)
      ZS_POS:  z_next = HALF_PI_Q30;
      ZS_NEG:  z_next = -HALF_PI_Q30;
      default: z_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= tag3;
      out_x   <= DW'(x3) <<< k;
      out_y   <= DW'(y3) <<< k;
      out_z   <= z_next;
    end
  end

endmodule

>>> rtl/nba_cell.sv
// One CORDIC vectoring micro-rotation, registered.
`timescale 1ns / 1ps

module nba_cell import nba_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  nba_tag_t             in_tag,
  input  logic signed [DW-1:0] in_x,
  input  logic signed [DW-1:0] in_y,
  input  logic signed [ZW-1:0] in_z,
  output logic                 out_vld,
  output nba_tag_t             out_tag,
  output logic signed [DW-1:0] out_x,
  output logic signed [DW-1:0] out_y,
  output logic signed [ZW-1:0] out_z
);

  logic signed [DW-1:0] xs, ys, x_next, y_next;
  logic signed [ZW-1:0] z_next;

  // Rotate toward the x axis; y strictly positive turns clockwise.
  always_comb begin
    xs = in_x >>> STEP;
    ys = in_y >>> STEP;
    if (!in_y[DW-1] && (in_y != '0)) begin
      x_next = in_x + ys;
      y_next = in_y - xs;
      z_next = in_z + ATAN_Q30[STEP];
    end else begin
      x_next = in_x - ys;
      y_next = in_y + xs;
      z_next = in_z - ATAN_Q30[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= in_tag;
      out_x   <= x_next;
      out_y   <= y_next;
      out_z   <= z_next;
    end
  end

endmodule

>>> rtl/neighbor_bearing_angle.sv
// Top level: skid register, front stages, normalizer, CORDIC cell row, output register.
`timescale 1ns / 1ps

// neighbor_bearing_angle computes the planar bearing atan2(dlat, dlon) from a
// center cell to one neighbor, in radians Q16 (0 east, pi/2 north). Inputs are
// signed fixed point degrees with COORD_FRAC_BITS fraction bits; the longitude
// difference is wrapped once into +-180 degrees. angle_valid is 0 (angle 0)
// when the center lies at a pole or neighbor_present is 0; equal points give
// angle 0 with angle_valid 1. The block takes one transaction per clock while
// out_ready does not stall it and returns results in order. Each transaction
// passes through two front stages (difference/wrap, quarter turn),
// two normalizer stages (leading-one search, shift), one stage per CORDIC
// micro-rotation, and the output register. A one-entry skid register on the
// input keeps in_ready high for one more transaction while a result waits on
// out_ready; the whole pipeline holds while the output register is stalled.
module neighbor_bearing_angle import nba_pkg::*; #(
  parameter int CORDIC_STEPS    = 16,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [23:0]        center_latitude,
  input  logic signed [24:0]        center_longitude,
  input  logic signed [23:0]        neighbor_latitude,
  input  logic signed [24:0]        neighbor_longitude,
  input  logic                      neighbor_present,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [ANGLE_W-1:0] angle,
  output logic                      angle_valid
);

  // Pipeline advance: move every stage when the output register is free or drained.
  logic en;
  assign en = !out_valid || out_ready;

  // Skid register: hold one transaction that arrives while the pipeline is stalled.
  logic               skid_full;
  logic signed [23:0] skid_clat, skid_nlat;
  logic signed [24:0] skid_clon, skid_nlon;
  logic               skid_present;
  logic               in_take;

  assign in_ready = !skid_full;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (en) begin
      skid_full <= 1'b0;
    end else if (in_take) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_take) begin
      skid_clat    <= center_latitude;
      skid_clon    <= center_longitude;
      skid_nlat    <= neighbor_latitude;
      skid_nlon    <= neighbor_longitude;
      skid_present <= neighbor_present;
    end
  end

  // Feed the front end from the skid register first, else from the ports.
  logic               f_vld;
  logic signed [23:0] f_clat, f_nlat;
  logic signed [24:0] f_clon, f_nlon;
  logic               f_present;

  always_comb begin
    f_vld     = skid_full || in_take;
    f_clat    = skid_full ? skid_clat    : center_latitude;
    f_clon    = skid_full ? skid_clon    : center_longitude;
    f_nlat    = skid_full ? skid_nlat    : neighbor_latitude;
    f_nlon    = skid_full ? skid_nlon    : neighbor_longitude;
    f_present = skid_full ? skid_present : neighbor_present;
  end

  // Front: differences, wrap, pole and empty-slot check, quarter turn.
  logic                 q_vld;
  nba_tag_t             q_tag;
  logic signed [XW-1:0] q_x, q_y;
  nba_zstart_t          q_zs;
  logic        [XW-1:0] q_orm;

  nba_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (f_vld),
    .clat    (f_clat),
    .clon    (f_clon),
    .nlat    (f_nlat),
    .nlon    (f_nlon),
    .present (f_present),
    .out_vld (q_vld),
    .out_tag (q_tag),
    .out_x   (q_x),
    .out_y   (q_y),
    .out_zs  (q_zs),
    .out_orm (q_orm)
  );

  // Cell row links: index 0 is the normalizer output, index CORDIC_STEPS the last cell.
  logic                 c_vld [CORDIC_STEPS+1];
  nba_tag_t             c_tag [CORDIC_STEPS+1];
  logic signed [DW-1:0] c_x   [CORDIC_STEPS+1];
  logic signed [DW-1:0] c_y   [CORDIC_STEPS+1];
  logic signed [ZW-1:0] c_z   [CORDIC_STEPS+1];

  nba_norm u_norm (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (q_vld),
    .in_tag  (q_tag),
    .in_x    (q_x),
    .in_y    (q_y),
    .in_zs   (q_zs),
    .in_orm  (q_orm),
    .out_vld (c_vld[0]),
    .out_tag (c_tag[0]),
    .out_x   (c_x[0]),
    .out_y   (c_y[0]),
    .out_z   (c_z[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    nba_cell #(
      .STEP(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (c_vld[i]),
      .in_tag  (c_tag[i]),
      .in_x    (c_x[i]),
      .in_y    (c_y[i]),
      .in_z    (c_z[i]),
      .out_vld (c_vld[i+1]),
      .out_tag (c_tag[i+1]),
      .out_x   (c_x[i+1]),
      .out_y   (c_y[i+1]),
      .out_z   (c_z[i+1])
    );
  end

  // Round Q30 to Q16 (floor after adding half an LSB), clamp, and force zero
  // for invalid slots and for equal points.
  logic signed [ZW-1:0]      z_round, z_clamp;
  logic signed [ANGLE_W-1:0] angle_next;
  nba_tag_t                  last_tag;

  always_comb begin
    last_tag = c_tag[CORDIC_STEPS];
    z_round  = (c_z[CORDIC_STEPS] + ROUND_BIAS) >>> ROUND_SHIFT;
    if (z_round > ANGLE_LIMIT) begin
      z_clamp = ANGLE_LIMIT;
    end else if (z_round < -ANGLE_LIMIT) begin
      z_clamp = -ANGLE_LIMIT;
    end else begin
      z_clamp = z_round;
    end
    angle_next = (last_tag.ok && last_tag.nz) ? ANGLE_W'(z_clamp) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle       <= angle_next;
      angle_valid <= last_tag.ok;
    end
  end

  // An invalid result always carries a zero angle.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !angle_valid |-> angle == '0)
    else $error("invalid result with nonzero angle");

  // The angle never leaves the clamp range.
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle <= ANGLE_W'(ANGLE_LIMIT)) && (angle >= -ANGLE_W'(ANGLE_LIMIT)))
    else $error("angle outside clamp range");

  // The skid register fills only while the pipeline is stalled.
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(!en))
    else $error("skid register filled while pipeline advanced");

  // A held transaction drains on the first advance.
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_full && en |=> !skid_full)
    else $error("skid register did not drain");

endmodule

>>> tb/sv/tb_neighbor_bearing_angle.sv
// Testbench for neighbor_bearing_angle: random and directed pairs checked against a CORDIC predictor.
`timescale 1ns / 1ps

module tb_neighbor_bearing_angle;

  localparam int CORDIC_STEPS    = 16;
  localparam int COORD_FRAC_BITS = 16;
  localparam int ANGLE_W         = nba_pkg::ANGLE_W;

  // Fixed point degree scale and the landmarks the block cares about.
  localparam int DEG    = 1 << COORD_FRAC_BITS;
  localparam int DEG90  = 90 * DEG;
  localparam int DEG180 = 180 * DEG;
  localparam int DEG360 = 360 * DEG;

  // CORDIC constants: Q30 radians, the clamp in Q16; kept here so a bad table in the RTL shows up.
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ANGLE_CLAMP = 64'sd205887;
  localparam longint NORM_FLOOR  = 64'sd1 << 39;
  localparam longint ATAN_STEP_Q30 [24] = '{
    843314856, 497837829, 263043836, 133525158,
    67021686,  33543515,  16775850,  8388437,
    4194282,   2097149,   1048575,   524287,
    262143,    131071,    65535,     32767,
    16383,     8191,      4095,      2047,
    1023,      511,       255,       127
  };

  localparam int RANDOM_PAIRS = 650;
  // Once fewer than this many pairs are left, neither side starts a new idle gap.
  localparam int TAIL_CALM    = 80;
  // Pipeline depth plus slack for the tail wait.
  localparam int DRAIN_CYCLES = CORDIC_STEPS + 12;
  localparam int TIMEOUT_NS   = 3_000_000;

  typedef struct {
    logic signed [23:0] clat;
    logic signed [24:0] clon;
    logic signed [23:0] nlat;
    logic signed [24:0] nlon;
    logic               present;
    bit                 wait_drained;  // hold this pair until every result is back
  } neighbor_pair_t;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic                      ok;
  } bearing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [23:0]        center_latitude = '0;
  logic signed [24:0]        center_longitude = '0;
  logic signed [23:0]        neighbor_latitude = '0;
  logic signed [24:0]        neighbor_longitude = '0;
  logic                      neighbor_present = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [ANGLE_W-1:0] angle;
  logic                      angle_valid;

  neighbor_pair_t pending_pairs[$];
  bearing_t       expected_bearings[$];
  int             mismatches = 0;

  // Set at the edge where the input transaction went through.
  logic in_took = 1'b0;

  // Pacing state for both sides.
  int in_gap = 0;
  int in_idle_pct = 0;
  int sent_count = 0;
  int out_gap = 0;
  int out_idle_pct = 0;
  int out_cycles = 0;

  neighbor_bearing_angle #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) DUT (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .center_latitude    (center_latitude),
    .center_longitude   (center_longitude),
    .neighbor_latitude  (neighbor_latitude),
    .neighbor_longitude (neighbor_longitude),
    .neighbor_present   (neighbor_present),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .angle              (angle),
    .angle_valid        (angle_valid)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Vectoring CORDIC: atan2(y, x) in Q16 radians, clamped to +-pi.
  function automatic longint cordic_vector_angle(input longint y_in, input longint x_in);
    longint x, y, z, t, ax, ay, mag, xs, ys;
    x = x_in;
    y = y_in;
    z = 0;
    // Fold the left half plane onto the right with a quarter turn.
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_Q30;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_Q30;
      end
    end
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    mag = (ax > ay) ? ax : ay;
    // Scale up for precision; atan2 does not care.
    while (mag < NORM_FLOOR) begin
      x = x * 2; y = y * 2; mag = mag * 2;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_STEP_Q30[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_STEP_Q30[i];
      end
    end
    z = (z + 8192) >>> 14;
    if (z > ANGLE_CLAMP) z = ANGLE_CLAMP;
    if (z < -ANGLE_CLAMP) z = -ANGLE_CLAMP;
    return z;
  endfunction

  // Bearing from center to neighbor, with the pole and empty-slot cases.
  function automatic bearing_t predict_bearing(input neighbor_pair_t p);
    bearing_t r;
    longint clat, clon, nlat, nlon, dlat, dlon, z;
    clat = longint'(p.clat);
    clon = longint'(p.clon);
    nlat = longint'(p.nlat);
    nlon = longint'(p.nlon);
    r.angle = '0;
    r.ok = 1'b0;
    if (((clat < 0) ? -clat : clat) < DEG90 && p.present) begin
      dlon = nlon - clon;
      // Wrap once only; exactly -180 stays as it is.
      if (dlon > DEG180) dlon = dlon - DEG360;
      else if (dlon < -DEG180) dlon = dlon + DEG360;
      dlat = nlat - clat;
      r.ok = 1'b1;
      if (dlon != 0 || dlat != 0) begin
        z = cordic_vector_angle(dlat, dlon);
        r.angle = z[ANGLE_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic add_pair(input int clat, input int clon, input int nlat, input int nlon,
                          input bit present, input bit wait_drained);
    neighbor_pair_t p;
    p.clat = 24'(clat);
    p.clon = 25'(clon);
    p.nlat = 24'(nlat);
    p.nlon = 25'(nlon);
    p.present = present;
    p.wait_drained = wait_drained;
    pending_pairs.push_back(p);
  endtask

  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Random pairs: mostly plausible neighbors near a valid center, plus
  // noise over the full field widths, poles, dateline crossings and empty slots.
  task automatic add_random_pair(input bit wait_drained);
    int kind, clat, clon, nlat, nlon, reach;
    bit present;
    kind = $urandom_range(0, 99);
    present = 1'b1;
    if (kind < 60) begin
      clat = pick(-DEG90 + 1, DEG90 - 1);
      clon = pick(-DEG180, DEG180);
      reach = 1 << $urandom_range(0, 22);
      nlat = clat + pick(-reach, reach);
      nlon = clon + pick(-reach, reach);
      case ($urandom_range(0, 9))
        0: nlat = clat;
        1: nlon = clon;
        default: ;
      endcase
      present = ($urandom_range(0, 19) != 0);
    end else if (kind < 75) begin
      clat = pick(-DEG90, DEG90);
      clon = pick(-DEG180, DEG180);
      nlat = pick(-DEG90, DEG90);
      nlon = pick(-DEG180, DEG180);
    end else if (kind < 85) begin
      clat = $urandom;
      clon = $urandom;
      nlat = $urandom;
      nlon = $urandom;
      present = 1'($urandom_range(0, 1));
    end else if (kind < 90) begin
      // Just short of, at, or just past either pole.
      clat = DEG90 + pick(-1, 200);
      if ($urandom_range(0, 1)) clat = -clat;
      clon = pick(-DEG180, DEG180);
      nlat = pick(-DEG90, DEG90);
      nlon = pick(-DEG180, DEG180);
    end else if (kind < 95) begin
      // Straddle the dateline so the wrap matters.
      clat = pick(-DEG90 + 1, DEG90 - 1);
      nlat = clat + pick(-DEG, DEG);
      clon = DEG180 - pick(0, 2 * DEG);
      nlon = -DEG180 + pick(0, 2 * DEG);
      if ($urandom_range(0, 1)) begin
        reach = clon; clon = nlon; nlon = reach;
      end
    end else begin
      clat = pick(-DEG90 + 1, DEG90 - 1);
      clon = pick(-DEG180, DEG180);
      nlat = clat;
      nlon = clon;
      if ($urandom_range(0, 1)) begin
        present = 1'b0;
        nlat = pick(-DEG90, DEG90);
      end
    end
    add_pair(clat, clon, nlat, nlon, present, wait_drained);
  endtask

  // Directed cases, then the random stream; reset and end of run.
  initial begin
    add_pair(0, 0, 0, 10 * DEG, 1, 0);                   // east
    add_pair(0, 0, 10 * DEG, 0, 1, 0);                   // north
    add_pair(0, 0, 0, -10 * DEG, 1, 0);                  // west, dlat zero
    add_pair(0, 0, -10 * DEG, 0, 1, 0);                  // south
    add_pair(5 * DEG, 20 * DEG, 8 * DEG, 15 * DEG, 1, 0);     // north-west
    add_pair(-5 * DEG, -20 * DEG, -9 * DEG, -27 * DEG, 1, 0); // south-west
    add_pair(12345, -67890, 12345, -67890, 1, 0);        // equal points
    add_pair(0, 0, 0, 0, 1, 0);
    add_pair(DEG, DEG, 3 * DEG, 2 * DEG, 0, 0);          // empty slot
    add_pair(DEG90, 0, 0, DEG, 1, 0);                    // north pole
    add_pair(-DEG90, 0, 0, DEG, 1, 0);                   // south pole
    add_pair(DEG90 - 1, 0, 0, DEG, 1, 0);                // just off the poles
    add_pair(-DEG90 + 1, 0, 0, DEG, 1, 0);
    add_pair(-(1 << 23), 0, 0, DEG, 1, 0);               // latitude beyond range
    add_pair((1 << 23) - 1, 0, 0, DEG, 1, 0);
    add_pair(0, 90 * DEG, DEG, -90 * DEG, 1, 0);         // exactly -180, not wrapped
    add_pair(0, 90 * DEG, 0, -90 * DEG, 1, 0);
    add_pair(0, -90 * DEG, -DEG, 90 * DEG, 1, 0);        // exactly +180
    add_pair(0, -90 * DEG, 0, 90 * DEG + 1, 1, 0);       // one step past +180
    add_pair(0, 90 * DEG, 0, -90 * DEG - 1, 1, 0);       // one step past -180
    add_pair(0, -(1 << 24), (1 << 23) - 1, (1 << 24) - 1, 1, 0); // field extremes
    add_pair(0, (1 << 24) - 1, -(1 << 23), -(1 << 24), 1, 0);
    add_pair(-DEG90 + 1, -DEG180, DEG90, DEG180, 1, 0);  // range extremes
    add_pair(0, 0, 1, 0, 1, 0);                          // one LSB moves
    add_pair(0, 0, -1, -1, 1, 0);
    add_pair(0, 0, 1, -1, 1, 1);
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      add_random_pair(n == 150 || n == 400);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the last transaction to go in, then for every result.
    while (pending_pairs.size() > 0 || in_valid) @(negedge clk);
    while (expected_bearings.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout, %0d pairs unsent, %0d results outstanding", $time,
             pending_pairs.size(), expected_bearings.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Input driver: present the next pair at the falling edge; hold it until taken.
  always @(negedge clk) begin : drive_pairs
    neighbor_pair_t p;
    bit send;
    send = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold: valid and payload stay put until the transaction completes
    end else begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_pairs.size() > 0) begin
        if (pending_pairs[0].wait_drained && expected_bearings.size() > 0) begin
          // hold off until the pipeline has emptied
        end else if (pending_pairs.size() >= TAIL_CALM &&
                     $urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(0, 15);
        end else begin
          send = 1'b1;
        end
      end
      if (send) begin
        p = pending_pairs.pop_front();
        center_latitude    <= p.clat;
        center_longitude   <= p.clon;
        neighbor_latitude  <= p.nlat;
        neighbor_longitude <= p.nlon;
        neighbor_present   <= p.present;
        sent_count++;
        // Change the input idling mix now and then, including idle-free stretches.
        if (sent_count % 50 == 0) begin
          case ($urandom_range(0, 3))
            0: in_idle_pct = 0;
            1: in_idle_pct = 5;
            2: in_idle_pct = 15;
            default: in_idle_pct = 35;
          endcase
        end
      end
      in_valid <= send;
    end
  end

  // Output pacing: stall out_ready in bursts, no new bursts once the tail is reached.
  always @(negedge clk) begin : pace_results
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_cycles++;
      if (out_cycles % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: out_idle_pct = 0;
          1: out_idle_pct = 3;
          2: out_idle_pct = 10;
          default: out_idle_pct = 25;
        endcase
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (pending_pairs.size() >= TAIL_CALM &&
                   $urandom_range(0, 99) < out_idle_pct) begin
        out_gap = $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each accepted pair, check each accepted result in order.
  always @(posedge clk) begin : check_bearings
    neighbor_pair_t seen;
    bearing_t want;
    in_took <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen.clat = center_latitude;
        seen.clon = center_longitude;
        seen.nlat = neighbor_latitude;
        seen.nlon = neighbor_longitude;
        seen.present = neighbor_present;
        seen.wait_drained = 1'b0;
        expected_bearings.push_back(predict_bearing(seen));
      end
      if (out_valid && out_ready) begin
        if (expected_bearings.size() == 0) begin
          $display("%0t: result with nothing expected: angle %0d angle_valid %0b",
                   $time, angle, angle_valid);
          mismatches++;
        end else begin
          want = expected_bearings.pop_front();
          if (angle !== want.angle) begin
            $display("%0t: angle mismatch: expected %0d, actual %0d",
                     $time, want.angle, angle);
            mismatches++;
          end
          if (angle_valid !== want.ok) begin
            $display("%0t: angle_valid mismatch: expected %0b, actual %0b",
                     $time, want.ok, angle_valid);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

>>> sim.f
rtl/nba_pkg.sv
rtl/nba_front.sv
rtl/nba_norm.sv
rtl/nba_cell.sv
rtl/neighbor_bearing_angle.sv
tb/sv/tb_neighbor_bearing_angle.sv
